// ===== rtl/sirt_pkg.sv =====
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared constants and types for the signed integer to radix text unit.
// ----------------------------------------------------------------------------
package sirt_pkg;

  // Alphabet store geometry.
  localparam int MAX_RADIX = 64;
  localparam int ALPHA_AW  = $clog2(MAX_RADIX);
  localparam int LEN_W     = $clog2(MAX_RADIX + 2);
  localparam int DIG_W     = ALPHA_AW;

  // Number and digit buffer geometry.
  localparam int NUM_W     = 32;
  localparam int DBUF_AW   = $clog2(NUM_W);
  localparam int ND_W      = DBUF_AW + 1;

  // Divider: bits of quotient retired per cycle and cycles per division.
  localparam int DIV_STEP  = 8;
  localparam int DIV_CYC   = NUM_W / DIV_STEP;
  localparam int DCNT_W    = $clog2(DIV_CYC);

  // Character codes.
  localparam logic [7:0] MINUS_BYTE = 8'h2D;
  localparam logic [7:0] PLUS_BYTE  = 8'h2B;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] DEL_BYTE   = 8'h7F;

  // Input modes.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MINUS,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT_RD,
    ST_LOOK,
    ST_PUT
  } sirt_state_t;

endpackage

// ===== rtl/signed_integer_to_radix_text_unit.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_unit
// Converts signed 32-bit numbers to text in a digit alphabet loaded by items.
// ----------------------------------------------------------------------------
// Usage:
//   Input items carry mode, restart_alphabet, symbol and number. A load item
//   appends one symbol to the alphabet RAM, or marks it invalid if it is
//   already full, and produces nothing. A convert item produces, when the
//   alphabet is valid, an optional minus sign and then the digits most
//   significant first; the final character has out_last set. Invalid
//   alphabets make a convert item produce nothing.
//   Input: in_stall is high while an item is being worked on. A load runs
//   a duplicate scan that reads the alphabet RAM one entry per cycle. A
//   conversion divides once per digit (8 quotient bits per cycle), then
//   reads the digit buffer and alphabet RAM for each character.
//   Output: results sit in an output register; while out_stall is high the
//   block waits with the next character. The next input item is accepted
//   while the final character still waits to be taken.
//   Reset: clears the alphabet length and bad flag and empties the output
//   register. The RAM contents need no clearing.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_unit
  import sirt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic              in_restart_alphabet,
  input  logic [7:0]        in_symbol,
  input  logic signed [31:0] in_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_text_char,
  output logic              out_last
);

  sirt_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               bad_r, bad_nxt;
  logic [7:0]         sym_r, sym_nxt;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic               scan_vld_r, scan_vld_nxt;
  logic [NUM_W-1:0]   mag_r, mag_nxt;
  logic [ND_W-1:0]    nd_r, nd_nxt;
  logic [DBUF_AW-1:0] idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic               a_we, a_re;
  logic [ALPHA_AW-1:0] a_waddr, a_raddr;
  logic [7:0]         a_wdata, a_rdata;
  logic               d_we, d_re;
  logic [DBUF_AW-1:0] d_waddr, d_raddr;
  logic [DIG_W-1:0]   d_wdata, d_rdata;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [LEN_W-1:0]   div_rem;

  // Control characters, space, plus, minus and delete cannot be digits.
  function automatic logic forbidden(input logic [7:0] s);
    return (s <= SPACE_BYTE) || (s == DEL_BYTE) || (s == MINUS_BYTE) ||
           (s == PLUS_BYTE);
  endfunction

  // Alphabet store.
  sirt_ram #(.WIDTH(8), .AW(ALPHA_AW)) u_alpha (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(a_wdata),
    .re   (a_re),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  // Digit buffer, filled least significant first and read back reversed.
  sirt_ram #(.WIDTH(DIG_W), .AW(DBUF_AW)) u_digits (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .re   (d_re),
    .raddr(d_raddr),
    .rdata(d_rdata)
  );

  sirt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Next state, memory controls and output register.
  always_comb begin
    logic [LEN_W-1:0] len_eff;
    logic             bad_eff;
    logic [NUM_W-1:0] num_u;
    logic             out_free;
    state_nxt     = state_r;
    len_nxt       = len_r;
    bad_nxt       = bad_r;
    sym_nxt       = sym_r;
    k_nxt         = k_r;
    scan_vld_nxt  = scan_vld_r;
    mag_nxt       = mag_r;
    nd_nxt        = nd_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    a_we          = 1'b0;
    a_waddr       = len_r[ALPHA_AW-1:0];
    a_wdata       = sym_r;
    a_re          = 1'b0;
    a_raddr       = k_r[ALPHA_AW-1:0];
    d_we          = 1'b0;
    d_waddr       = nd_r[DBUF_AW-1:0];
    d_wdata       = div_rem[DIG_W-1:0];
    d_re          = 1'b0;
    d_raddr       = idx_r;
    div_start     = 1'b0;
    len_eff       = in_restart_alphabet ? '0 : len_r;
    bad_eff       = in_restart_alphabet ? 1'b0 : bad_r;
    num_u         = $unsigned(in_number);
    out_free      = !out_valid_r || !out_stall;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            if (len_eff >= LEN_W'(MAX_RADIX)) begin
              len_nxt = LEN_W'(MAX_RADIX + 1);
              bad_nxt = bad_eff;
            end else begin
              len_nxt      = len_eff;
              bad_nxt      = bad_eff | forbidden(in_symbol);
              sym_nxt      = in_symbol;
              k_nxt        = '0;
              scan_vld_nxt = 1'b0;
              state_nxt    = ST_SCAN;
            end
          end else if (!bad_r && len_r >= LEN_W'(2) && len_r <= LEN_W'(MAX_RADIX)) begin
            mag_nxt   = num_u[NUM_W-1] ? (~num_u + 1'b1) : num_u;
            nd_nxt    = '0;
            state_nxt = num_u[NUM_W-1] ? ST_MINUS : ST_DIV_GO;
          end
        end
      end

      // Compare the new symbol against every stored one, then append it.
      ST_SCAN: begin
        if (scan_vld_r && a_rdata == sym_r) begin
          bad_nxt = 1'b1;
        end
        if (k_r < len_r) begin
          a_re         = 1'b1;
          k_nxt        = k_r + 1'b1;
          scan_vld_nxt = 1'b1;
        end else begin
          scan_vld_nxt = 1'b0;
          if (!scan_vld_r) begin
            a_we      = 1'b1;
            len_nxt   = len_r + 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_MINUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = MINUS_BYTE;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIV_GO;
        end
      end

      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end

      // Store one digit; continue while the quotient is nonzero.
      ST_DIV_WAIT: begin
        if (div_done) begin
          d_we    = 1'b1;
          nd_nxt  = nd_r + 1'b1;
          mag_nxt = div_quo;
          if (div_quo == '0) begin
            idx_nxt   = nd_r[DBUF_AW-1:0];
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = ST_DIV_GO;
          end
        end
      end

      ST_EMIT_RD: begin
        d_re      = 1'b1;
        state_nxt = ST_LOOK;
      end

      // Map the digit value to its alphabet symbol.
      ST_LOOK: begin
        a_re      = 1'b1;
        a_raddr   = d_rdata;
        state_nxt = ST_PUT;
      end

      ST_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = a_rdata;
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      bad_r       <= 1'b0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      bad_r       <= bad_nxt;
      scan_vld_r  <= scan_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    k_r        <= k_nxt;
    mag_r      <= mag_nxt;
    nd_r       <= nd_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/sirt_ram.sv =====
// ----------------------------------------------------------------------------
// sirt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sirt_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:(1 << AW)-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sirt_div.sv =====
// ----------------------------------------------------------------------------
// sirt_div
// Iterative unsigned divider of a 32-bit value by a narrow radix.
// ----------------------------------------------------------------------------
module sirt_div
  import sirt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [LEN_W-1:0] remainder
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  div_r, div_nxt;

  // Restoring division, several quotient bits per cycle. The partial
  // remainder stays below the divisor, so it never needs more bits.
  always_comb begin
    logic [LEN_W:0]      t;
    logic [LEN_W-1:0]    rem;
    logic [DIV_STEP-1:0] qbits;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    rem      = rem_r;
    qbits    = '0;
    t        = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      for (int i = 0; i < DIV_STEP; i++) begin
        t = {rem, quo_r[NUM_W-1-i]};
        if (t >= {1'b0, div_r}) begin
          t = t - {1'b0, div_r};
          qbits[DIV_STEP-1-i] = 1'b1;
        end
        rem = t[LEN_W-1:0];
      end
      rem_nxt = rem;
      quo_nxt = {quo_r[NUM_W-DIV_STEP-1:0], qbits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
